[sv/saad_pkg.sv]
package saad_pkg;

	localparam int SAMPLE_BITS_DEF  = 15;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int TAB_LEN          = 24;

	// angles in 1/65536 degree
	localparam int ANG_W = 26;
	localparam logic signed [ANG_W-1:0] ANG_FULL = 26'sd23592960;
	localparam logic signed [ANG_W-1:0] ANG_HALF = 26'sd11796480;

	// fine altitude in 1/64 foot
	localparam logic [16:0] FT_1000 = 17'd64000;
	localparam logic [16:0] FT_800  = 17'd51200;
	localparam logic [16:0] FT_200  = 17'd12800;

	localparam int OUT_W = 96;

	function automatic logic [21:0] atan_entry(input logic [4:0] i);
		logic [21:0] v;
		unique case (i)
			5'd0:    v = 22'd2949120;
			5'd1:    v = 22'd1740967;
			5'd2:    v = 22'd919879;
			5'd3:    v = 22'd466945;
			5'd4:    v = 22'd234379;
			5'd5:    v = 22'd117304;
			5'd6:    v = 22'd58666;
			5'd7:    v = 22'd29335;
			5'd8:    v = 22'd14668;
			5'd9:    v = 22'd7334;
			5'd10:   v = 22'd3667;
			5'd11:   v = 22'd1833;
			5'd12:   v = 22'd917;
			5'd13:   v = 22'd458;
			5'd14:   v = 22'd229;
			5'd15:   v = 22'd115;
			5'd16:   v = 22'd57;
			5'd17:   v = 22'd29;
			5'd18:   v = 22'd14;
			5'd19:   v = 22'd7;
			5'd20:   v = 22'd4;
			5'd21:   v = 22'd2;
			5'd22:   v = 22'd1;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

endpackage

[sv/synchro_attitude_altitude_decoder.sv]
// Synchro attitude and altitude decoder.
// Input: one frame per s_tvalid/s_tready transfer, seven offset-binary ADC
// samples packed in s_tdata. Output: one result per frame on m_tvalid/
// m_tready, packed in m_tdata.
// Pitch, roll and the thousands seed are worked out in the accept cycle.
// One iterative vectoring CORDIC then resolves the fine altitude dial angle,
// a bit-serial divide by nine scales it to feet, and the same CORDIC
// resolves heading. s_tready is high only while no frame is in work, so
// a new frame is taken only once the last has passed through the shared
// CORDIC and the serial divider and been written to the output register.
// The result sits in an output register; a stalled receiver holds it and
// the next frame may be accepted and worked meanwhile, but that frame's
// result waits until the register is taken.
// Reset clears the thousands count, the last dial reading and the seeded
// flag: the first frame after reset seeds the thousands count from the
// coarse altitude sample.
module synchro_attitude_altitude_decoder #(
	parameter int SAMPLE_BITS  = saad_pkg::SAMPLE_BITS_DEF,
	parameter int CORDIC_STEPS = saad_pkg::CORDIC_STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// pitch_sample, roll_sample, coarse_alt_sample, alt_sin_sample,
	// alt_cos_sample, hdg_sin_sample, hdg_cos_sample, zero fill
	input  logic [((7*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// pitch_deg, roll_deg, heading_deg, fine_alt_ft, altitude_ft,
	// thousands_count, zero fill
	output logic [saad_pkg::OUT_W-1:0] m_tdata
);

	localparam int SB    = SAMPLE_BITS;
	localparam int DW    = SB + 1;
	localparam int CW    = SB + 11;
	localparam int PMW   = DW + 14;
	localparam int TMW   = DW + 4;
	localparam int AW    = saad_pkg::ANG_W;
	localparam int NSTEP = (CORDIC_STEPS > saad_pkg::TAB_LEN) ? saad_pkg::TAB_LEN : CORDIC_STEPS;
	localparam logic [4:0] LAST_STEP = 5'(NSTEP - 1);
	localparam logic [4:0] LAST_DIV  = 5'd19;
	localparam logic [DW-1:0] CENTRE = DW'(2 ** (SB - 1));

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ALT   = 3'd1;
	localparam logic [2:0] ST_SCALE = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_ROLL  = 3'd4;
	localparam logic [2:0] ST_HDG   = 3'd5;
	localparam logic [2:0] ST_OUT   = 3'd6;

	logic [2:0] state_q;
	logic [4:0] step_q;
	logic signed [CW-1:0] x_q, y_q;
	logic signed [AW-1:0] z_q;
	logic zero_q;
	logic [19:0] t_q;
	logic [3:0] rem_q;
	logic [SB-1:0] hs_q, hc_q;
	logic signed [4:0] th_q;
	logic [16:0] last_fine_q;
	logic seeded_q;
	logic [14:0] pitch_q, roll_q;
	logic [15:0] fine_q;
	logic [20:0] tot_q;

	logic accept;
	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;

	// sample offsets
	logic signed [DW-1:0] d_pitch, d_roll, d_coarse, d_as, d_ac;
	assign d_pitch  = $signed({1'b0, s_tdata[0*SB +: SB]} - CENTRE);
	assign d_roll   = $signed({1'b0, s_tdata[1*SB +: SB]} - CENTRE);
	assign d_coarse = $signed({1'b0, s_tdata[2*SB +: SB]} - CENTRE);
	assign d_as     = $signed({1'b0, s_tdata[3*SB +: SB]} - CENTRE);
	assign d_ac     = $signed({1'b0, s_tdata[4*SB +: SB]} - CENTRE);

	// attitude scaling: round(d * 11520 / centre), halves up
	logic [PMW-1:0] pm_p, pm_r;
	logic signed [PMW-1:0] ps_p, ps_r;
	assign pm_p = {{14{d_pitch[DW-1]}}, d_pitch} * PMW'(11520) + PMW'(CENTRE >> 1);
	assign pm_r = {{14{d_roll[DW-1]}}, d_roll} * PMW'(11520) + PMW'(CENTRE >> 1);
	assign ps_p = $signed(pm_p) >>> (SB - 1);
	assign ps_r = $signed(pm_r) >>> (SB - 1);

	// thousands seed, truncated toward zero
	logic [TMW-1:0] tm, tm_adj;
	logic signed [TMW-1:0] tm_sh;
	assign tm = {{4{d_coarse[DW-1]}}, d_coarse} * TMW'(10);
	assign tm_adj = tm[TMW-1] ? tm + TMW'(CENTRE - DW'(1)) : tm;
	assign tm_sh = $signed(tm_adj) >>> (SB - 1);

	// CORDIC load
	logic signed [DW-1:0] ld_s, ld_c;
	logic signed [CW-1:0] ld_x, ld_y;
	assign ld_s = (state_q == ST_IDLE) ? d_as : $signed({1'b0, hs_q} - CENTRE);
	assign ld_c = (state_q == ST_IDLE) ? d_ac : $signed({1'b0, hc_q} - CENTRE);
	assign ld_x = {{2{ld_c[DW-1]}}, ld_c, 8'b0};
	assign ld_y = {{2{ld_s[DW-1]}}, ld_s, 8'b0};

	// CORDIC step
	logic signed [CW-1:0] dx, dy;
	logic signed [AW-1:0] tab;
	assign dx = y_q >>> step_q;
	assign dy = x_q >>> step_q;
	assign tab = $signed({4'b0, saad_pkg::atan_entry(step_q)});

	// fold into one turn
	logic signed [AW-1:0] zf;
	logic [24:0] ang;
	always_comb begin
		priority if (zero_q) zf = '0;
		else if (z_q < 0) zf = z_q + saad_pkg::ANG_FULL;
		else if (z_q >= saad_pkg::ANG_FULL) zf = z_q - saad_pkg::ANG_FULL;
		else zf = z_q;
	end
	assign ang = zf[24:0];

	logic [35:0] scaled;
	assign scaled = 36'(ang) * 36'd1600 + 36'd294912;

	// serial divide by nine
	logic [4:0] dr;
	logic dq;
	assign dr = {rem_q, t_q[19]};
	assign dq = (dr >= 5'd9);

	// roll-over tracking
	logic [19:0] fw;
	logic [16:0] fine;
	logic signed [4:0] th_new;
	always_comb begin
		fw = 20'(saad_pkg::FT_1000) - t_q;
		fine = fw[16:0];
		priority if (last_fine_q >= saad_pkg::FT_800 && fine < saad_pkg::FT_200
				&& th_q < 5'sd9)
			th_new = th_q + 5'sd1;
		else if (last_fine_q < saad_pkg::FT_200 && fine >= saad_pkg::FT_800
				&& th_q > 5'sd0)
			th_new = th_q - 5'sd1;
		else
			th_new = th_q;
	end

	logic [20:0] tot;
	assign tot = {{16{th_new[4]}}, th_new} * 21'd64000 + {4'b0, fine};

	logic [25:0] hr;
	logic [17:0] hd;
	assign hr = {1'b0, ang} + 26'd128;
	assign hd = hr[25:8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			th_q <= '0;
			last_fine_q <= '0;
			seeded_q <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (state_q == ST_OUT && (!m_tvalid || m_tready))
				m_tvalid <= 1'b1;
			else if (m_tvalid && m_tready)
				m_tvalid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!seeded_q) begin
							th_q <= tm_sh[4:0];
							seeded_q <= 1'b1;
						end
						state_q <= ST_ALT;
					end
				end
				ST_ALT: begin
					if (step_q == LAST_STEP)
						state_q <= ST_SCALE;
				end
				ST_SCALE: state_q <= ST_DIV;
				ST_DIV: begin
					if (step_q == LAST_DIV)
						state_q <= ST_ROLL;
				end
				ST_ROLL: begin
					th_q <= th_new;
					last_fine_q <= fine;
					state_q <= ST_HDG;
				end
				ST_HDG: begin
					if (step_q == LAST_STEP)
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!m_tvalid || m_tready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				pitch_q <= ps_p[14:0];
				roll_q <= ps_r[14:0];
				hs_q <= s_tdata[5*SB +: SB];
				hc_q <= s_tdata[6*SB +: SB];
			end
			ST_SCALE: begin
				t_q <= scaled[35:16];
				rem_q <= '0;
			end
			ST_DIV: begin
				rem_q <= dq ? 4'(dr - 5'd9) : dr[3:0];
				t_q <= {t_q[18:0], dq};
			end
			ST_ROLL: begin
				fine_q <= fine[15:0];
				tot_q <= tot;
			end
			ST_OUT: begin
				// heading angle is final here; 360 degrees wraps to 0
				if (!m_tvalid || m_tready)
					m_tdata <= {7'b0, th_q, tot_q, fine_q,
						(hd == 18'd92160) ? 17'd0 : hd[16:0], roll_q, pitch_q};
			end
			default: ;
		endcase

		// shared step counter and CORDIC datapath
		if (state_q == ST_IDLE || state_q == ST_ROLL || state_q == ST_SCALE) begin
			step_q <= '0;
		end else if (state_q == ST_ALT || state_q == ST_HDG || state_q == ST_DIV) begin
			step_q <= step_q + 5'd1;
		end

		if (state_q == ST_IDLE || state_q == ST_ROLL) begin
			zero_q <= (ld_s == '0) && (ld_c == '0);
			if (ld_x < 0) begin
				x_q <= -ld_x;
				y_q <= -ld_y;
				z_q <= saad_pkg::ANG_HALF;
			end else begin
				x_q <= ld_x;
				y_q <= ld_y;
				z_q <= '0;
			end
		end else if (state_q == ST_ALT || state_q == ST_HDG) begin
			if (y_q > 0) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + tab;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - tab;
			end
		end
	end

endmodule

[sim/tb_synchro_attitude_altitude_decoder.sv]
`timescale 1ns / 100ps

module tb_synchro_attitude_altitude_decoder;

	localparam int SB = 15;
	localparam int CENTER = 1 << (SB - 1);
	localparam int STEPS = 16;
	localparam int IN_W = ((7*SB+7)/8)*8;
	localparam longint DEG_FULL = 360 * 65536;
	localparam longint DEG_HALF = 180 * 65536;
	localparam longint LIMIT_CYCLES = 4000000;

	typedef struct {
		logic [14:0] pitch, roll, coarse, alt_sin, alt_cos, hdg_sin, hdg_cos;
	} frame_t;

	typedef struct {
		logic signed [14:0] pitch_deg;
		logic signed [14:0] roll_deg;
		logic [16:0] heading_deg;
		logic [15:0] fine_alt_ft;
		logic signed [20:0] altitude_ft;
		logic signed [4:0] thousands_count;
	} decoded_t;

	class decode_scoreboard;
		decoded_t pending[$];
		int errors;
		longint thousands, last_fine;
		bit seeded;

		function new();
			errors = 0;
			thousands = 0;
			last_fine = 0;
			seeded = 0;
		endfunction

		function longint div_near(longint num, longint den);
			longint n, q;
			n = num + den / 2;
			q = n / den;
			if (n % den < 0)
				q--;
			return q;
		endfunction

		function longint angle_of(longint y, longint x);
			longint z, dx, dy;
			longint tbl[24];
			tbl = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
				14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
			z = 0;
			if (x == 0 && y == 0)
				return 0;
			x = x * 256;
			y = y * 256;
			if (x < 0) begin
				x = -x;
				y = -y;
				z = DEG_HALF;
			end
			for (int i = 0; i < STEPS && i < 24; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (y > 0) begin
					x += dx;
					y -= dy;
					z += tbl[i];
				end else begin
					x -= dx;
					y += dy;
					z -= tbl[i];
				end
			end
			if (z < 0) z += DEG_FULL;
			if (z < 0) z += DEG_FULL;
			if (z >= DEG_FULL) z -= DEG_FULL;
			return z;
		endfunction

		function void note(frame_t f);
			decoded_t e;
			longint fine, hdg;
			e.pitch_deg = 15'(div_near((longint'(f.pitch) - CENTER) * 11520, CENTER));
			e.roll_deg = 15'(div_near((longint'(f.roll) - CENTER) * 11520, CENTER));
			if (!seeded) begin
				thousands = ((longint'(f.coarse) - CENTER) * 10) / CENTER;
				seeded = 1;
			end
			fine = 64000 - div_near(angle_of(longint'(f.alt_sin) - CENTER,
				longint'(f.alt_cos) - CENTER) * 64000, DEG_FULL);
			if (fine < 0)
				fine = 0;
			if (last_fine >= 51200 && fine < 12800 && thousands < 9)
				thousands++;
			else if (last_fine < 12800 && fine >= 51200 && thousands > 0)
				thousands--;
			last_fine = fine;
			hdg = div_near(angle_of(longint'(f.hdg_sin) - CENTER,
				longint'(f.hdg_cos) - CENTER), 256);
			if (hdg >= 92160)
				hdg -= 92160;
			e.heading_deg = 17'(hdg);
			e.fine_alt_ft = 16'(fine);
			e.altitude_ft = 21'(thousands * 64000 + fine);
			e.thousands_count = 5'(thousands);
			pending.push_back(e);
		endfunction

		function void check(logic [95:0] d);
			decoded_t e;
			if (pending.size() == 0) begin
				$error("unexpected result %h", d);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (d[14:0] !== e.pitch_deg) begin
				$error("pitch_deg exp %0d got %0d", e.pitch_deg, $signed(d[14:0]));
				errors++;
			end
			if (d[29:15] !== e.roll_deg) begin
				$error("roll_deg exp %0d got %0d", e.roll_deg, $signed(d[29:15]));
				errors++;
			end
			if (d[46:30] !== e.heading_deg) begin
				$error("heading_deg exp %0d got %0d", e.heading_deg, d[46:30]);
				errors++;
			end
			if (d[62:47] !== e.fine_alt_ft) begin
				$error("fine_alt_ft exp %0d got %0d", e.fine_alt_ft, d[62:47]);
				errors++;
			end
			if (d[83:63] !== e.altitude_ft) begin
				$error("altitude_ft exp %0d got %0d", e.altitude_ft, $signed(d[83:63]));
				errors++;
			end
			if (d[88:84] !== e.thousands_count) begin
				$error("thousands_count exp %0d got %0d", e.thousands_count,
					$signed(d[88:84]));
				errors++;
			end
			if (d[95:89] !== 7'd0) begin
				$error("zero fill exp 0 got %h", d[95:89]);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [95:0] m_tdata;

	decode_scoreboard sb = new();
	longint cycles = 0;
	bit rx_steady = 0;
	int rx_hold = 0;

	synchro_attitude_altitude_decoder DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 93) return $urandom_range(1, 4);
		return $urandom_range(20, 150);
	endfunction

	// receiver: check on transfer, then choose next tready
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check(m_tdata);
			if (rx_steady || rx_hold == 0) begin
				m_tready <= 1'b1;
				if (!rx_steady && $urandom_range(0, 9) == 0)
					rx_hold = pick_gap();
			end else begin
				m_tready <= 1'b0;
				rx_hold--;
			end
		end
	end

	task automatic send(frame_t f);
		int g;
		s_tdata <= {7'd0, f.hdg_cos, f.hdg_sin, f.alt_cos, f.alt_sin, f.coarse,
			f.roll, f.pitch};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note(f);
		g = rx_steady ? 0 : pick_gap();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	function frame_t rand_frame();
		frame_t f;
		f.pitch = 15'($urandom);
		f.roll = 15'($urandom);
		f.coarse = 15'($urandom);
		f.alt_sin = 15'($urandom);
		f.alt_cos = 15'($urandom);
		f.hdg_sin = 15'($urandom);
		f.hdg_cos = 15'($urandom);
		return f;
	endfunction

	// dial and heading at given angles in degrees, radius in counts
	function frame_t dial_frame(real alt_a, real hdg_a, int radius);
		frame_t f;
		real pi;
		pi = 3.14159265358979;
		f = rand_frame();
		f.alt_sin = 15'(CENTER + $rtoi(radius * $sin(alt_a * pi / 180.0)));
		f.alt_cos = 15'(CENTER + $rtoi(radius * $cos(alt_a * pi / 180.0)));
		f.hdg_sin = 15'(CENTER + $rtoi(radius * $sin(hdg_a * pi / 180.0)));
		f.hdg_cos = 15'(CENTER + $rtoi(radius * $cos(hdg_a * pi / 180.0)));
		return f;
	endfunction

	initial begin
		frame_t f;
		real a;
		int wait_cnt;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first frame: seed at top of coarse range, dial near 1000 ft rolls down
		f = dial_frame(10.0, 0.0, 16000);
		f.coarse = 15'h7FFF;
		send(f);
		f = '{15'h0000, 15'h0000, 15'h0000, 15'h0000, 15'h0000, 15'h0000, 15'h0000};
		send(f);
		f = '{15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF};
		send(f);
		f = '{CENTER, CENTER, CENTER, CENTER, CENTER, CENTER, CENTER};
		send(f);
		f = '{15'h5555, 15'h2AAA, 15'h5555, 15'h2AAA, 15'h5555, 15'h2AAA, 15'h5555};
		send(f);
		// axis crossings, including sin-only and negative cos
		f = '{CENTER, CENTER, 0, 15'h7FFF, CENTER, 0, CENTER};
		send(f);
		f = '{CENTER, CENTER, 0, CENTER, 0, CENTER, 0};
		send(f);
		f = '{CENTER, CENTER, 0, 0, CENTER, 15'h7FFF, CENTER};
		send(f);
		// wrap the dial backward across zero to roll up, then forward to roll down
		for (int k = 0; k < 12; k++) begin
			send(dial_frame(30.0, 90.0 * k, 12000));
			send(dial_frame(330.0, 45.0 * k, 12000));
		end
		for (int k = 0; k < 12; k++) begin
			send(dial_frame(330.0, 10.0 * k, 9000));
			send(dial_frame(30.0, 359.9, 9000));
		end

		a = 0.0;
		for (int n = 0; n < 1700; n++) begin
			if (n == 300) rx_steady = 1;
			if (n == 400) rx_steady = 0;
			if ($urandom_range(0, 9) < 8) begin
				a = a + $itor($urandom_range(0, 120)) - 60.0;
				if (a < 0.0) a = a + 360.0;
				if (a >= 360.0) a = a - 360.0;
				send(dial_frame(a, $itor($urandom_range(0, 35999)) / 100.0,
					$urandom_range(1, 16383)));
			end else begin
				send(rand_frame());
			end
		end
		s_tvalid <= 1'b0;

		wait_cnt = 0;
		while (sb.pending.size() != 0 && wait_cnt < 100000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (100) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[filelist.f]
sv/saad_pkg.sv
sv/synchro_attitude_altitude_decoder.sv
sim/tb_synchro_attitude_altitude_decoder.sv
